@@ hw/rtl/tfwrr_pkg.sv @@
// tfwrr_pkg: shared types, constants and helpers for the three-queue
// weighted round-robin ticket arbiter. No dependencies.
package tfwrr_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int TICKET_BITS = 16;
	localparam int NUM_QUEUES  = 3;

	// external field widths
	localparam int TICKET_W = 16;

	// stored ticket width: only the low TICKET_BITS of the 16-bit field survive
	localparam int STORE_W = (TICKET_BITS < TICKET_W) ? TICKET_BITS : TICKET_W;
	// fill count runs 0 .. QUEUE_DEPTH inclusive
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

	// command codes
	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_SERVE  = 1'b1;

	// queue codes
	localparam logic [1:0] QSEL_NORMAL_ONE = 2'd0;
	localparam logic [1:0] QSEL_NORMAL_TWO = 2'd1;
	localparam logic [1:0] QSEL_PREFERRED  = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_STORED  = 2'd0;
	localparam logic [1:0] STATUS_DROPPED = 2'd1;
	localparam logic [1:0] STATUS_SERVED  = 2'd2;
	localparam logic [1:0] STATUS_EMPTY   = 2'd3;

	typedef struct packed {
		logic                command;
		logic [1:0]          queue_select;
		logic [TICKET_W-1:0] ticket;
	} item_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [TICKET_W-1:0] served_ticket;
		logic [1:0]          served_queue;
	} result_t;

	// per-queue control from the arbiter
	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctrl_t;

	// per-queue status back to the arbiter
	typedef struct packed {
		logic               full;
		logic               empty;
		logic [STORE_W-1:0] head;
	} queue_stat_t;

	// turn cycle: normal one, preferred, normal two, preferred
	function automatic logic [1:0] phase_to_queue(input logic [1:0] phase);
		logic [1:0] q;
		case (phase)
			2'd0:    q = QSEL_NORMAL_ONE;
			2'd1:    q = QSEL_PREFERRED;
			2'd2:    q = QSEL_NORMAL_TWO;
			2'd3:    q = QSEL_PREFERRED;
			default: q = QSEL_NORMAL_ONE;
		endcase
		return q;
	endfunction

endpackage

@@ hw/rtl/tfwrr_cell.sv @@
// tfwrr_cell: one entry of a shifting ticket queue.
// Depends on tfwrr_pkg for the stored ticket width.
module tfwrr_cell
	import tfwrr_pkg::*;
(
	input  logic               clk,
	input  logic               load,
	input  logic               shift,
	input  logic [STORE_W-1:0] load_data,
	input  logic [STORE_W-1:0] next_data,
	output logic [STORE_W-1:0] data_q
);

	// take the neighbor's entry on a pop, or the new ticket when this is the tail slot
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= next_data;
		end else if (load) begin
			data_q <= load_data;
		end
	end

endmodule

@@ hw/rtl/tfwrr_queue.sv @@
// tfwrr_queue: bounded ticket FIFO built as a row of shifting cells, head at cell 0.
// Depends on tfwrr_pkg and tfwrr_cell.
module tfwrr_queue
	import tfwrr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  queue_ctrl_t        ctrl,
	input  logic [STORE_W-1:0] push_data,
	output queue_stat_t        stat
);

	logic [CNT_W-1:0]   count_q;
	logic [STORE_W-1:0] cell_data [QUEUE_DEPTH];
	logic [STORE_W-1:0] cell_next [QUEUE_DEPTH];

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// row of cells, each shifting toward the head on a pop
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign cell_next[i] = cell_data[i];
		end else begin : g_mid
			assign cell_next[i] = cell_data[i+1];
		end

		tfwrr_cell u_cell (
			.clk       (clk),
			.load      (ctrl.push && (count_q == CNT_W'(i))),
			.shift     (ctrl.pop),
			.load_data (push_data),
			.next_data (cell_next[i]),
			.data_q    (cell_data[i])
		);
	end

	// status toward the arbiter
	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.head  = cell_data[0];

endmodule

@@ hw/rtl/three_fifo_weighted_round_robin.sv @@
// Three-queue weighted round-robin ticket arbiter, top level.
// Depends on tfwrr_pkg and tfwrr_queue.
//
// Usage:
//   item channel (item, item_valid, item_stall) carries one request: an
//   arrival appends a ticket to normal one, normal two or the preferred
//   queue; a serve takes the head of the queue whose turn it is. Turns run
//   normal one, preferred, normal two, preferred and advance on every serve,
//   even when that queue is empty (status reports an empty slot).
//   result channel (result, result_valid, result_stall) returns exactly one
//   result per request, in order.
// Timing:
//   one request per cycle while item_stall is low; the result is shown
//   from the output register in the cycle after acceptance. Queue update
//   (cell rows), head read and turn advance finish in the accepting cycle.
// Stall:
//   while a result is held by result_stall, item_stall is raised; a new
//   request is taken in the same cycle the held result leaves.
// Reset:
//   arst_n empties all queues, returns the turn to normal one and clears
//   result_valid. Queue contents are not cleared.
module three_fifo_weighted_round_robin
	import tfwrr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    item_valid,
	output logic    item_stall,
	output result_t result,
	output logic    result_valid,
	input  logic    result_stall
);

	logic               accept;
	logic [1:0]         phase_q;
	logic [1:0]         turn_queue;
	logic               result_valid_q;
	result_t            result_q;
	result_t            result_d;
	queue_ctrl_t        ctrl [NUM_QUEUES];
	queue_stat_t        stat [NUM_QUEUES];
	logic [STORE_W-1:0] store_data;
	logic [STORE_W-1:0] head_sel;
	logic               any_push;
	logic               turn_empty;

	// handshake
	assign item_stall   = result_valid_q && result_stall;
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign turn_queue = phase_to_queue(phase_q);
	assign store_data = STORE_W'(item.ticket);

	// per-queue push/pop decode and head selection
	always_comb begin
		any_push   = 1'b0;
		turn_empty = 1'b0;
		head_sel   = '0;
		for (int k = 0; k < NUM_QUEUES; k++) begin
			ctrl[k].push = accept && (item.command == CMD_ARRIVE)
				&& (item.queue_select == 2'(k)) && !stat[k].full;
			ctrl[k].pop  = accept && (item.command == CMD_SERVE)
				&& (turn_queue == 2'(k)) && !stat[k].empty;
			any_push = any_push | ctrl[k].push;
			if (turn_queue == 2'(k)) begin
				turn_empty = stat[k].empty;
				head_sel   = stat[k].head;
			end
		end
	end

	// result assembly
	always_comb begin
		result_d = '0;
		if (item.command == CMD_ARRIVE) begin
			result_d.status = any_push ? STATUS_STORED : STATUS_DROPPED;
		end else begin
			result_d.served_queue = turn_queue;
			if (turn_empty) begin
				result_d.status = STATUS_EMPTY;
			end else begin
				result_d.status        = STATUS_SERVED;
				result_d.served_ticket = TICKET_W'(head_sel);
			end
		end
	end

	// the three queues
	for (genvar k = 0; k < NUM_QUEUES; k++) begin : g_queue
		tfwrr_queue u_queue (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[k]),
			.push_data (store_data),
			.stat      (stat[k])
		);
	end

	// turn phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept && (item.command == CMD_SERVE)) begin
			phase_q <= phase_q + 2'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

endmodule

@@ hw/rtl/tfwrr_checker.sv @@
// tfwrr_checker: port-level checks for the arbiter top level, bound in below.
// Depends on tfwrr_pkg and three_fifo_weighted_round_robin.
module tfwrr_checker
	import tfwrr_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input result_t result,
	input logic    result_valid,
	input logic    result_stall
);

	// upstream is held back only by a result waiting downstream
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("item_stall without a held result");

	// every accepted request shows a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> result_valid)
		else $error("accepted request produced no result");

	// a delivered result is not repeated without a new request
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && !(item_valid && !item_stall)) |=> !result_valid)
		else $error("result repeated");

	// arrival results carry no ticket and no queue; empty turns carry no ticket
	a_field_rules: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.served_queue != 2'd3)
			&& ((result.status == STATUS_SERVED) || (result.served_ticket == '0))
			&& ((result.status == STATUS_SERVED) || (result.status == STATUS_EMPTY)
				|| (result.served_queue == QSEL_NORMAL_ONE))))
		else $error("result fields inconsistent with status");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result changed");

endmodule

bind three_fifo_weighted_round_robin tfwrr_checker u_tfwrr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result       (result),
	.result_valid (result_valid),
	.result_stall (result_stall)
);

@@ tb/tb_three_fifo_weighted_round_robin.sv @@
// tb_three_fifo_weighted_round_robin: self-checking testbench for the three-queue
// weighted round-robin ticket arbiter, with a scoreboard that tracks the queues.
// Depends on tfwrr_pkg and three_fifo_weighted_round_robin.
module tb_three_fifo_weighted_round_robin;
	import tfwrr_pkg::*;

	// arrival to a queue that does not exist
	localparam logic [1:0] QSEL_NONE = 2'd3;

	localparam int RANDOM_REQUESTS = 900;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 8;

	// receiver stall modes
	localparam int STALL_NONE   = 0;
	localparam int STALL_LIGHT  = 1;
	localparam int STALL_BURSTY = 2;

	// tracks queue contents and turn order, holds the outcomes still awaited
	class ticket_scoreboard;
		logic [STORE_W-1:0] slots [NUM_QUEUES][QUEUE_DEPTH];
		int unsigned        head_idx [NUM_QUEUES];
		int unsigned        tail_idx [NUM_QUEUES];
		int unsigned        fill [NUM_QUEUES];
		logic [1:0]         turn;
		result_t            awaited_outcomes [$];
		int                 errors;

		function new();
			for (int q = 0; q < NUM_QUEUES; q++) begin
				head_idx[q] = 0;
				tail_idx[q] = 0;
				fill[q]     = 0;
			end
			turn   = 2'd0;
			errors = 0;
		endfunction

		// queue served in each turn of the four-step cycle
		function logic [1:0] turn_queue(input logic [1:0] t);
			logic [1:0] q;
			if (t == 2'd0)
				q = QSEL_NORMAL_ONE;
			else if (t == 2'd2)
				q = QSEL_NORMAL_TWO;
			else
				q = QSEL_PREFERRED;
			return q;
		endfunction

		// apply an accepted request and queue its outcome
		function void note_request(input item_t req);
			result_t    outcome;
			logic [1:0] q;
			outcome = '0;
			if (req.command == CMD_ARRIVE) begin
				q = req.queue_select;
				if (req.queue_select == QSEL_NONE) begin
					outcome.status = STATUS_DROPPED;
				end else if (fill[q] >= QUEUE_DEPTH) begin
					outcome.status = STATUS_DROPPED;
				end else begin
					slots[q][tail_idx[q]] = req.ticket[STORE_W-1:0];
					tail_idx[q] = (tail_idx[q] + 1) % QUEUE_DEPTH;
					fill[q]++;
					outcome.status = STATUS_STORED;
				end
			end else begin
				q = turn_queue(turn);
				outcome.served_queue = q;
				if (fill[q] == 0) begin
					outcome.status = STATUS_EMPTY;
				end else begin
					outcome.served_ticket = TICKET_W'(slots[q][head_idx[q]]);
					head_idx[q] = (head_idx[q] + 1) % QUEUE_DEPTH;
					fill[q]--;
					outcome.status = STATUS_SERVED;
				end
				turn = turn + 2'd1;
			end
			awaited_outcomes.push_back(outcome);
		endfunction

		function int pending();
			return awaited_outcomes.size();
		endfunction

		task report(input string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		// compare an accepted result with the oldest awaited outcome
		task check_outcome(input result_t got);
			result_t want;
			if (awaited_outcomes.size() == 0) begin
				report($sformatf("unexpected result status=%0d ticket=%h queue=%0d",
					got.status, got.served_ticket, got.served_queue));
			end else begin
				want = awaited_outcomes.pop_front();
				if (got.status !== want.status)
					report($sformatf("status got %0d want %0d", got.status, want.status));
				if (got.served_ticket !== want.served_ticket)
					report($sformatf("served_ticket got %h want %h",
						got.served_ticket, want.served_ticket));
				if (got.served_queue !== want.served_queue)
					report($sformatf("served_queue got %0d want %0d",
						got.served_queue, want.served_queue));
			end
		endtask

		task finish_check();
			if (awaited_outcomes.size() != 0)
				report($sformatf("%0d results never arrived", awaited_outcomes.size()));
		endtask
	endclass

	logic    clk;
	logic    arst_n;
	item_t   item;
	logic    item_valid;
	logic    item_stall;
	result_t result;
	logic    result_valid;
	logic    result_stall;

	ticket_scoreboard sb;
	bit draining;
	bit valid_up;
	int burst_left;
	int idle_cycles;
	int stall_mode;
	int mode_left;
	int run_left;

	three_fifo_weighted_round_robin i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	always #2 clk = ~clk;

	function automatic item_t make_request(input logic cmd, input logic [1:0] qsel,
		input logic [TICKET_W-1:0] tk);
		item_t req;
		req.command      = cmd;
		req.queue_select = qsel;
		req.ticket       = tk;
		return req;
	endfunction

	// drive one request until accepted, then idle between bursts
	task automatic send_request(input item_t req);
		int gap;
		item       <= req;
		item_valid <= 1'b1;
		valid_up   = 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_request(req);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
			if (gap > 0) begin
				item_valid <= 1'b0;
				valid_up   = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// random segments: arrival-heavy ones fill queues, serve-heavy ones drain them
	task automatic send_random(input int count);
		int          sent;
		int          seg_len;
		int          arrive_pct;
		int          favored;
		logic        cmd;
		logic [1:0]  qsel;
		sent = 0;
		while (sent < count) begin
			seg_len = $urandom_range(20, 80);
			case ($urandom_range(0, 3))
				0:       arrive_pct = 100;
				1:       arrive_pct = 80;
				2:       arrive_pct = 50;
				default: arrive_pct = 15;
			endcase
			favored = ($urandom_range(0, 2) == 0) ? $urandom_range(0, NUM_QUEUES - 1) : -1;
			for (int i = 0; i < seg_len && sent < count; i++) begin
				cmd = ($urandom_range(0, 99) < arrive_pct) ? CMD_ARRIVE : CMD_SERVE;
				if ($urandom_range(0, 19) == 0)
					qsel = QSEL_NONE;
				else if (favored >= 0 && $urandom_range(0, 3) != 0)
					qsel = favored[1:0];
				else
					qsel = 2'($urandom_range(0, NUM_QUEUES - 1));
				send_request(make_request(cmd, qsel, TICKET_W'($urandom_range(0, 65535))));
				sent++;
			end
		end
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (!arst_n || draining) begin
			result_stall <= 1'b0;
		end else begin
			if (mode_left <= 0) begin
				stall_mode = $urandom_range(STALL_NONE, STALL_BURSTY);
				mode_left  = $urandom_range(20, 80);
			end
			mode_left--;
			case (stall_mode)
				STALL_NONE:  result_stall <= 1'b0;
				STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
				default: begin
					if (run_left > 0) begin
						run_left--;
						result_stall <= 1'b1;
					end else if ($urandom_range(0, 4) == 0) begin
						run_left = $urandom_range(0, 7);
						result_stall <= 1'b1;
					end else begin
						result_stall <= 1'b0;
					end
				end
			endcase
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_outcome(result);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_three_fifo_weighted_round_robin: done, errors");
				$finish;
			end
		end
	end

	initial begin
		sb           = new();
		clk          = 1'b0;
		arst_n       = 1'b0;
		item         = '0;
		item_valid   = 1'b0;
		result_stall = 1'b0;
		draining     = 1'b0;
		valid_up     = 1'b0;
		burst_left   = 1;
		idle_cycles  = 0;
		stall_mode   = STALL_NONE;
		mode_left    = 0;
		run_left     = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// serves on empty queues through every turn
		for (int i = 0; i < 4; i++)
			send_request(make_request(CMD_SERVE, 2'($urandom_range(0, 3)), 16'hFFFF));
		// arrival to the nonexistent queue, then extreme tickets
		send_request(make_request(CMD_ARRIVE, QSEL_NONE, 16'hFFFF));
		send_request(make_request(CMD_ARRIVE, QSEL_NORMAL_ONE, 16'h0000));
		send_request(make_request(CMD_ARRIVE, QSEL_NORMAL_TWO, 16'hFFFF));
		// preferred queue filled past full
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			send_request(make_request(CMD_ARRIVE, QSEL_PREFERRED,
				i[0] ? (16'h5555 ^ 16'(i)) : 16'hAAAA));

		send_random(RANDOM_REQUESTS);

		if (valid_up)
			item_valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		draining = 1'b1;
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.finish_check();

		if (sb.errors == 0)
			$display("tb_three_fifo_weighted_round_robin: done, clean");
		else
			$display("tb_three_fifo_weighted_round_robin: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/tfwrr_pkg.sv
hw/rtl/tfwrr_cell.sv
hw/rtl/tfwrr_queue.sv
hw/rtl/three_fifo_weighted_round_robin.sv
hw/rtl/tfwrr_checker.sv
tb/tb_three_fifo_weighted_round_robin.sv
